// ----- rtl/nca_pkg.sv -----
package nca_pkg;

    localparam int IDX_W     = 3;
    localparam int CNT_W     = 16;
    localparam int SUM_W     = 32;
    localparam int M_TDATA_W = 104;

    // s_axis_tuser values
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } op_t;

    // one center read in flight through the distance pipeline
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } scan_tag_t;

    typedef struct packed {
        logic [SUM_W-1:0] rep_total;
        logic [SUM_W-1:0] dem_total;
        logic [SUM_W-1:0] pop_total;
        logic [IDX_W-1:0] chosen_index;
    } result_t;

endpackage

// ----- rtl/nca_center_mem.sv -----
module nca_center_mem import nca_pkg::*; #(
    parameter int NUM_DISTRICTS = 3,
    parameter int COORD_BITS    = 16,
    localparam int AW = (NUM_DISTRICTS > 1) ? $clog2(NUM_DISTRICTS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic signed [COORD_BITS-1:0] wr_x,
    input  logic signed [COORD_BITS-1:0] wr_y,
    input  logic [AW-1:0]                rd_addr,
    output logic signed [COORD_BITS-1:0] rd_x,
    output logic signed [COORD_BITS-1:0] rd_y
);

    logic [2*COORD_BITS-1:0]  center_mem [NUM_DISTRICTS];
    logic [NUM_DISTRICTS-1:0] cvalid_reg;
    logic [2*COORD_BITS-1:0]  rd_data_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            center_mem[wr_addr] <= {wr_y, wr_x};
        end
        rd_data_reg <= center_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvalid_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                cvalid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= cvalid_reg[rd_addr];
        end
    end

    // a center never loaded sits at the origin
    assign rd_x = rd_valid_reg ? rd_data_reg[COORD_BITS-1:0] : '0;
    assign rd_y = rd_valid_reg ? rd_data_reg[2*COORD_BITS-1:COORD_BITS] : '0;

endmodule

// ----- rtl/nca_dist_unit.sv -----
module nca_dist_unit import nca_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  scan_tag_t                    tag_in,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    input  logic signed [COORD_BITS-1:0] cen_x,
    input  logic signed [COORD_BITS-1:0] cen_y,
    output logic [IDX_W-1:0]             best_idx,
    output logic                         done
);

    localparam int DW = 2 * COORD_BITS + 1;

    scan_tag_t                 tag0_reg, tag1_reg, tag2_reg;
    logic [COORD_BITS-1:0]     ax_reg, ay_reg;
    logic [2*COORD_BITS-1:0]   sqx_reg, sqy_reg;
    logic [DW-1:0]             best_dist_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic                      done_reg;

    logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
    logic [DW-1:0]              dist_sum;
    logic                       take;

    always_comb begin
        dx       = {pt_x[COORD_BITS-1], pt_x} - {cen_x[COORD_BITS-1], cen_x};
        dy       = {pt_y[COORD_BITS-1], pt_y} - {cen_y[COORD_BITS-1], cen_y};
        ndx      = -dx;
        ndy      = -dy;
        dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        // strict compare keeps the lowest index on equal distance
        take     = tag2_reg.vld && (tag2_reg.first || (dist_sum < best_dist_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            tag2_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            tag0_reg <= tag_in;
            tag1_reg <= tag0_reg;
            tag2_reg <= tag1_reg;
            done_reg <= tag2_reg.vld && tag2_reg.last;
        end
    end

    // magnitude of a difference always fits in COORD_BITS unsigned bits
    always_ff @(posedge aclk) begin
        ax_reg  <= dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ay_reg  <= dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        sqx_reg <= ax_reg * ax_reg;
        sqy_reg <= ay_reg * ay_reg;
        if (take) begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= tag2_reg.idx;
        end
    end

    assign best_idx = best_idx_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/nca_accum.sv -----
module nca_accum import nca_pkg::*; #(
    parameter int NUM_DISTRICTS = 3,
    localparam int AW = (NUM_DISTRICTS > 1) ? $clog2(NUM_DISTRICTS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr_en,
    input  logic [AW-1:0]    clr_addr,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             acc_en,
    input  logic [CNT_W-1:0] add_pop,
    input  logic [CNT_W-1:0] add_dem,
    input  logic [CNT_W-1:0] add_rep,
    output logic [SUM_W-1:0] pop_total,
    output logic [SUM_W-1:0] dem_total,
    output logic [SUM_W-1:0] rep_total
);

    logic [3*SUM_W-1:0]       sum_mem [NUM_DISTRICTS];
    logic [NUM_DISTRICTS-1:0] svalid_reg;
    logic [3*SUM_W-1:0]       rd_data_reg;
    logic                     rd_valid_reg;
    logic [AW-1:0]            addr_reg;
    logic [SUM_W-1:0]         pop_old, dem_old, rep_old;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W-CNT_W+1){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    always_comb begin
        pop_old   = rd_valid_reg ? rd_data_reg[SUM_W-1:0] : '0;
        dem_old   = rd_valid_reg ? rd_data_reg[2*SUM_W-1:SUM_W] : '0;
        rep_old   = rd_valid_reg ? rd_data_reg[3*SUM_W-1:2*SUM_W] : '0;
        pop_total = sat_add(pop_old, add_pop);
        dem_total = sat_add(dem_old, add_dem);
        rep_total = sat_add(rep_old, add_rep);
    end

    // write back goes to the entry at the address registered by the last read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= sum_mem[rd_addr];
            addr_reg    <= rd_addr;
        end
        if (acc_en) begin
            sum_mem[addr_reg] <= {rep_total, dem_total, pop_total};
        end
    end

    // clearing a district only drops its valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            svalid_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_valid_reg <= svalid_reg[rd_addr];
            end
            if (acc_en) begin
                svalid_reg[addr_reg] <= 1'b1;
            end else if (clr_en) begin
                svalid_reg[clr_addr] <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/nearest_center_assign_accumulate.sv -----
// channel  dir  handshake              payload
// s_axis   in   tvalid/tready          tuser: op; tdata: index, x, y, pop, dem, rep
// m_axis   out  tvalid/tready          tdata: chosen_index, pop, dem, rep totals
//
// a point goes from transfer in to result valid through these steps:
// one center memory read per district, the distance pipeline, then the sum
// read, the write back and the output register load. a load goes to the output register load.
// reset clears valid bits only, so every center starts at the origin with zero sums.
// a result waits in the output register while the next item is taken in; if it is
// still there when the next result is done, s_axis_tready stays low until it leaves.
module nearest_center_assign_accumulate import nca_pkg::*; #(
    parameter int NUM_DISTRICTS = 3,
    parameter int COORD_BITS    = 16,
    localparam int S_FIELDS_W = IDX_W + 2 * COORD_BITS + 3 * CNT_W,
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // district_index, coord_x, coord_y, point_pop, point_dem, point_rep
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // chosen_index, pop_total, dem_total, rep_total
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW    = (NUM_DISTRICTS > 1) ? $clog2(NUM_DISTRICTS) : 1;
    localparam int PAD_W = M_TDATA_W - $bits(result_t);
    localparam int OFS_X = IDX_W;
    localparam int OFS_Y = OFS_X + COORD_BITS;
    localparam int OFS_P = OFS_Y + COORD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_ACC,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [AW-1:0]           k_reg;
    logic signed [COORD_BITS-1:0] pt_x_reg, pt_y_reg;
    logic [CNT_W-1:0]        pop_reg, dem_reg, rep_reg;
    result_t                 res_reg;
    logic                    m_valid_reg;
    logic [M_TDATA_W-1:0]    m_data_reg;

    logic                    s_fire;
    logic [IDX_W-1:0]        s_idx;
    logic signed [COORD_BITS-1:0] s_x, s_y;
    logic                    load_ok;
    logic                    load_en;
    logic                    out_load;
    scan_tag_t               tag;
    logic signed [COORD_BITS-1:0] cen_x, cen_y;
    logic [IDX_W-1:0]        best_idx;
    logic                    dist_done;
    logic                    sum_rd_en;
    logic                    acc_en;
    logic [SUM_W-1:0]        pop_total, dem_total, rep_total;

    always_comb begin
        s_axis_tready = (state_reg == ST_IDLE);
        s_fire        = s_axis_tvalid && s_axis_tready;
        s_idx         = s_axis_tdata[IDX_W-1:0];
        s_x           = s_axis_tdata[OFS_X +: COORD_BITS];
        s_y           = s_axis_tdata[OFS_Y +: COORD_BITS];
        load_ok       = ({1'b0, s_idx} < (IDX_W+1)'(NUM_DISTRICTS));
        load_en       = s_fire && (s_axis_tuser == OP_LOAD) && load_ok;
        tag.vld       = (state_reg == ST_SCAN);
        tag.first     = (k_reg == '0);
        tag.last      = (k_reg == AW'(NUM_DISTRICTS - 1));
        tag.idx       = IDX_W'(k_reg);
        sum_rd_en     = (state_reg == ST_WAIT) && dist_done;
        acc_en        = (state_reg == ST_ACC);
        // output register frees up in the same cycle it transfers
        out_load      = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);
    end

    nca_center_mem #(
        .NUM_DISTRICTS (NUM_DISTRICTS),
        .COORD_BITS    (COORD_BITS)
    ) u_center_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_en),
        .wr_addr (s_idx[AW-1:0]),
        .wr_x    (s_x),
        .wr_y    (s_y),
        .rd_addr (k_reg),
        .rd_x    (cen_x),
        .rd_y    (cen_y)
    );

    nca_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tag_in   (tag),
        .pt_x     (pt_x_reg),
        .pt_y     (pt_y_reg),
        .cen_x    (cen_x),
        .cen_y    (cen_y),
        .best_idx (best_idx),
        .done     (dist_done)
    );

    nca_accum #(
        .NUM_DISTRICTS (NUM_DISTRICTS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr_en    (load_en),
        .clr_addr  (s_idx[AW-1:0]),
        .rd_en     (sum_rd_en),
        .rd_addr   (best_idx[AW-1:0]),
        .acc_en    (acc_en),
        .add_pop   (pop_reg),
        .add_dem   (dem_reg),
        .add_rep   (rep_reg),
        .pop_total (pop_total),
        .dem_total (dem_total),
        .rep_total (rep_total)
    );

    // item payload and result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pt_x_reg <= s_x;
            pt_y_reg <= s_y;
            pop_reg  <= s_axis_tdata[OFS_P +: CNT_W];
            dem_reg  <= s_axis_tdata[OFS_P + CNT_W +: CNT_W];
            rep_reg  <= s_axis_tdata[OFS_P + 2 * CNT_W +: CNT_W];
            res_reg  <= '{rep_total: '0, dem_total: '0, pop_total: '0, chosen_index: s_idx};
        end
        if (sum_rd_en) begin
            res_reg.chosen_index <= best_idx;
        end
        if (acc_en) begin
            res_reg.pop_total <= pop_total;
            res_reg.dem_total <= dem_total;
            res_reg.rep_total <= rep_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    k_reg <= '0;
                    if (s_fire) begin
                        state_reg <= (s_axis_tuser == OP_POINT) ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    k_reg <= k_reg + AW'(1);
                    if (tag.last) begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (dist_done) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {{PAD_W{1'b0}}, res_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- bench/tb_nearest_center_assign_accumulate.sv -----
module tb_nearest_center_assign_accumulate import nca_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DISTRICTS = 3;
    localparam int COORD_BITS    = 16;
    localparam int S_TDATA_W     = ((IDX_W + 2 * COORD_BITS + 3 * CNT_W + 7) / 8) * 8;
    localparam int S_PAD_W       = S_TDATA_W - (IDX_W + 2 * COORD_BITS + 3 * CNT_W);
    localparam int RES_W         = $bits(result_t);
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = NUM_DISTRICTS + 16;
    localparam int PHASE_ITEMS   = 167;

    typedef struct {
        op_t                     op;
        logic [IDX_W-1:0]        idx;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [CNT_W-1:0]        pop;
        logic [CNT_W-1:0]        dem;
        logic [CNT_W-1:0]        rep;
    } district_item_t;

    typedef struct {
        district_item_t item;
        bit             typed;
        result_t        want;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // reference copy of the block state
    logic signed [COORD_BITS-1:0] center_x [NUM_DISTRICTS];
    logic signed [COORD_BITS-1:0] center_y [NUM_DISTRICTS];
    logic [SUM_W-1:0]             pop_sum [NUM_DISTRICTS];
    logic [SUM_W-1:0]             dem_sum [NUM_DISTRICTS];
    logic [SUM_W-1:0]             rep_sum [NUM_DISTRICTS];

    result_t       expected_totals [$];
    directed_row_t directed_rows [$];
    int            mismatch_count = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            quiet_cycles = 0;

    nearest_center_assign_accumulate #(
        .NUM_DISTRICTS(NUM_DISTRICTS),
        .COORD_BITS   (COORD_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [SUM_W-1:0] want,
                                   input logic [SUM_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - CNT_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic longint sq_distance(input district_item_t it, input int k);
        longint dx;
        longint dy;
        dx = longint'(it.x) - longint'(center_x[k]);
        dy = longint'(it.y) - longint'(center_y[k]);
        return dx * dx + dy * dy;
    endfunction

    // updates the state copy and returns the totals the block should report
    function automatic result_t nearest_center_update(input district_item_t it);
        result_t r;
        longint  best_d;
        longint  d;
        int      best;
        r = '0;
        if (it.op == OP_LOAD) begin
            if (it.idx < NUM_DISTRICTS) begin
                center_x[it.idx] = it.x;
                center_y[it.idx] = it.y;
                pop_sum[it.idx]  = '0;
                dem_sum[it.idx]  = '0;
                rep_sum[it.idx]  = '0;
            end
            r.chosen_index = it.idx;
            return r;
        end
        best = 0;
        best_d = sq_distance(it, 0);
        for (int k = 1; k < NUM_DISTRICTS; k++) begin
            d = sq_distance(it, k);
            // strict compare keeps the lowest index on a tie
            if (d < best_d) begin
                best_d = d;
                best = k;
            end
        end
        pop_sum[best] = sat_sum(pop_sum[best], it.pop);
        dem_sum[best] = sat_sum(dem_sum[best], it.dem);
        rep_sum[best] = sat_sum(rep_sum[best], it.rep);
        r.chosen_index = IDX_W'(best);
        r.pop_total    = pop_sum[best];
        r.dem_total    = dem_sum[best];
        r.rep_total    = rep_sum[best];
        return r;
    endfunction

    task automatic send_item(input district_item_t it, input bit typed, input result_t want);
        result_t predicted;
        int      gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {{S_PAD_W{1'b0}}, it.rep, it.dem, it.pop, it.y, it.x, it.idx};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        predicted = nearest_center_update(it);
        expected_totals.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_totals.size() != 0)
            @(posedge aclk);
    endtask

    function automatic void add_row(input op_t op, input int idx, input int x, input int y,
                                    input int pop, input int dem, input int rep,
                                    input bit typed, input int w_idx, input int w_pop,
                                    input int w_dem, input int w_rep);
        directed_row_t row;
        row.item.op  = op;
        row.item.idx = IDX_W'(idx);
        row.item.x   = COORD_BITS'(x);
        row.item.y   = COORD_BITS'(y);
        row.item.pop = CNT_W'(pop);
        row.item.dem = CNT_W'(dem);
        row.item.rep = CNT_W'(rep);
        row.typed    = typed;
        row.want.chosen_index = IDX_W'(w_idx);
        row.want.pop_total    = SUM_W'(w_pop);
        row.want.dem_total    = SUM_W'(w_dem);
        row.want.rep_total    = SUM_W'(w_rep);
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(9))
            0: return {1'b1, {(COORD_BITS - 1){1'b0}}};
            1: return {1'b0, {(COORD_BITS - 1){1'b1}}};
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return CNT_W'($urandom);
        endcase
    endfunction

    function automatic district_item_t random_item();
        district_item_t it;
        int             k;
        k = $urandom_range(NUM_DISTRICTS - 1);
        it.op  = ($urandom_range(99) < 15) ? OP_LOAD : OP_POINT;
        it.idx = IDX_W'($urandom_range(7));
        it.x   = rand_coord();
        it.y   = rand_coord();
        it.pop = rand_count();
        it.dem = rand_count();
        it.rep = rand_count();
        if (it.op == OP_LOAD) begin
            if ($urandom_range(99) < 80)
                it.idx = IDX_W'($urandom_range(NUM_DISTRICTS - 1));
            // stacked centers give ties
            if ($urandom_range(99) < 20) begin
                it.x = center_x[k];
                it.y = center_y[k];
            end
        end else begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    it.x = center_x[k] + COORD_BITS'($urandom_range(4)) - COORD_BITS'(2);
                    it.y = center_y[k] + COORD_BITS'($urandom_range(4)) - COORD_BITS'(2);
                end
                3: begin
                    it.x = center_x[k];
                    it.y = center_y[k];
                end
                default: ;
            endcase
        end
        return it;
    endfunction

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = result_t'(m_axis_tdata[RES_W-1:0]);
            if (expected_totals.size() == 0) begin
                report_mismatch("result transfer with nothing expected, index", '0,
                                SUM_W'(got.chosen_index));
            end else begin
                want = expected_totals.pop_front();
                if (got.chosen_index !== want.chosen_index)
                    report_mismatch("chosen_index", SUM_W'(want.chosen_index),
                                    SUM_W'(got.chosen_index));
                if (got.pop_total !== want.pop_total)
                    report_mismatch("pop_total", want.pop_total, got.pop_total);
                if (got.dem_total !== want.dem_total)
                    report_mismatch("dem_total", want.dem_total, got.dem_total);
                if (got.rep_total !== want.rep_total)
                    report_mismatch("rep_total", want.rep_total, got.rep_total);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        district_item_t it;
        result_t        none;
        none = '0;
        for (int k = 0; k < NUM_DISTRICTS; k++) begin
            center_x[k] = '0;
            center_y[k] = '0;
            pop_sum[k]  = '0;
            dem_sum[k]  = '0;
            rep_sum[k]  = '0;
        end

        // every center at the origin after reset, so the first point ties to district 0
        add_row(OP_POINT, 0, 100, -50, 10, 20, 30, 1, 0, 10, 20, 30);
        add_row(OP_POINT, 5, -1, 1, 65535, 0, 65535, 0, 0, 0, 0, 0);
        add_row(OP_LOAD, 0, -32768, -32768, 65535, 65535, 65535, 1, 0, 0, 0, 0);
        add_row(OP_LOAD, 1, 32767, 32767, 0, 0, 0, 1, 1, 0, 0, 0);
        add_row(OP_LOAD, 2, 32767, -32768, 1, 2, 3, 1, 2, 0, 0, 0);
        // out of range loads write nothing
        add_row(OP_LOAD, 3, 100, 100, 7, 7, 7, 1, 3, 0, 0, 0);
        add_row(OP_LOAD, 7, -1, -1, 65535, 65535, 65535, 1, 7, 0, 0, 0);
        add_row(OP_POINT, 0, -32768, -32768, 65535, 65535, 65535, 0, 0, 0, 0, 0);
        add_row(OP_POINT, 7, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_POINT, 2, 32767, -32768, 65535, 1, 0, 0, 0, 0, 0, 0);
        add_row(OP_POINT, 0, -32768, 32767, 1, 1, 1, 0, 0, 0, 0, 0);
        add_row(OP_LOAD, 2, 32767, 32767, 9, 9, 9, 1, 2, 0, 0, 0);
        add_row(OP_POINT, 3, 0, 0, 5, 6, 7, 0, 0, 0, 0, 0);
        add_row(OP_POINT, 1, 32767, 32767, 65535, 65535, 65535, 0, 0, 0, 0, 0);
        add_row(OP_LOAD, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(OP_LOAD, 1, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
        add_row(OP_LOAD, 2, 0, 0, 0, 0, 0, 1, 2, 0, 0, 0);
        add_row(OP_POINT, 4, -32768, -32768, 43690, 21845, 65535, 0, 0, 0, 0, 0);
        add_row(OP_POINT, 6, 1, 0, 21845, 43690, 0, 0, 0, 0, 0, 0);
        add_row(OP_LOAD, 1, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0);
        add_row(OP_POINT, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0);
        add_row(OP_POINT, 0, -1, 0, 2, 2, 2, 0, 0, 0, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 36;
        rx_idle_pct = 45;
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 45;
                end
                1: begin
                    tx_idle_pct = 45;
                    rx_idle_pct = 36;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = random_item();
                send_item(it, 1'b0, none);
            end
            // hold off until the block has caught up
            if (phase == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/nca_pkg.sv
rtl/nca_center_mem.sv
rtl/nca_dist_unit.sv
rtl/nca_accum.sv
rtl/nearest_center_assign_accumulate.sv
bench/tb_nearest_center_assign_accumulate.sv
